// ===== design/assert_macros.svh =====
// Assertion macros used by the design's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NLP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NLP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define NLP_ASSERT(label, clk, rst, prop, msg)
`define NLP_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== design/nlp_pkg.sv =====
// Types, constants and character helpers for the numeric literal parser.
package nlp_pkg;

   localparam int MAX_LEN = 255;
   localparam logic [7:0] COUNT_CAP = 8'((MAX_LEN < 255) ? MAX_LEN : 255);

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 80;
   localparam int KIND_W     = 3;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_D = 8'h64;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_L = 8'h6C;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CASE_GAP   = 8'h20;
   localparam logic [7:0] HEX_LONG_BYTES = 8'd8;

   localparam logic [KIND_W-1:0] KIND_UINT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ULONG = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LONG  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLOAT = 3'd4;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_SIGN   = 5'b00010,
      PH_LOOK   = 5'b00100,
      PH_DIGITS = 5'b01000,
      PH_HEX    = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC      = 2'd0,
      RX_HEX      = 2'd1,
      RX_BIN      = 2'd2,
      RX_HEX_LONG = 2'd3
   } radix_type;

   typedef struct packed {
      phase_type   phase;
      logic [63:0] accum;
      logic        negative;
      radix_type   radix_sel;
      logic [7:0]  held_char;
      logic [7:0]  char_count;
      logic [4:0]  digit_limit;
   } state_type;

   typedef struct packed {
      logic [63:0]       value;
      logic [KIND_W-1:0] kind;
      logic [7:0]        consumed;
      logic [7:0]        stop_char;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
   endfunction

   function automatic digit_type digit_of(input logic [7:0] c, input radix_type rx);
      digit_type  d;
      logic [7:0] l;
      l = to_lower(c);
      d.ok  = 1'b0;
      d.val = 4'd0;
      if (rx == RX_BIN) begin
         if (c == CH_ZERO || c == CH_ONE) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_ZERO);
         end
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         d.ok  = 1'b1;
         d.val = 4'(c - CH_ZERO);
      end else if (rx != RX_DEC && l >= CH_LOWER_A && l <= CH_LOWER_F) begin
         d.ok  = 1'b1;
         d.val = 4'(l - CH_LOWER_A + 8'd10);
      end
      return d;
   endfunction

   function automatic logic [7:0] count_up(input logic [7:0] cnt, input logic [1:0] n);
      logic [8:0] sum;
      sum = {1'b0, cnt} + {7'd0, n};
      return (sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : sum[7:0];
   endfunction

endpackage

// ===== design/nlp_step.sv =====
// Next-state and result logic for one character of the literal parser.
module nlp_step (
   input  nlp_pkg::state_type  cur,
   input  logic [7:0]          ch,
   input  logic                start_req,
   input  logic [3:0]          hex_bytes,
   output nlp_pkg::state_type  nxt,
   output logic                emit,
   output nlp_pkg::result_type res
);
   import nlp_pkg::*;

   state_type  eff;
   digit_type  d_c;
   digit_type  d_held;
   digit_type  d_hex;
   logic [7:0] low_c;
   logic [6:0] two_dec;
   logic [63:0] scaled;
   logic [4:0] limit_dec;

   // Closes a general literal on a stop character.
   function automatic result_type finish(input logic [63:0] acc, input logic neg,
                                         input logic [7:0] c, input logic [7:0] cnt);
      result_type r;
      logic [7:0] s;
      logic [63:0] negacc;
      s      = to_lower(c);
      negacc = 64'd0 - acc;
      r.stop_char = c;
      r.consumed  = cnt;
      if (s == CH_LOWER_L) begin
         r.consumed = count_up(cnt, 2'd1);
         r.value    = neg ? negacc : acc;
         r.kind     = neg ? KIND_LONG : KIND_ULONG;
      end else if (s == CH_DOT || s == CH_LOWER_E || s == CH_LOWER_D || s == CH_LOWER_F) begin
         r.value = 64'd0;
         r.kind  = KIND_FLOAT;
      end else if (neg) begin
         r.value = {acc[63:32], negacc[31:0]};
         r.kind  = KIND_INT;
      end else begin
         r.value = acc;
         r.kind  = KIND_UINT;
      end
      return r;
   endfunction

   always_comb begin
      eff = cur;
      if (start_req) begin
         eff.accum      = 64'd0;
         eff.negative   = 1'b0;
         eff.held_char  = 8'd0;
         eff.char_count = 8'd0;
         if (hex_bytes != 4'd0) begin
            eff.digit_limit = {hex_bytes, 1'b0};
            eff.radix_sel   = ({4'd0, hex_bytes} == HEX_LONG_BYTES) ? RX_HEX_LONG : RX_HEX;
            eff.phase       = PH_HEX;
         end else begin
            eff.digit_limit = 5'd0;
            eff.radix_sel   = RX_DEC;
            eff.phase       = PH_SIGN;
         end
      end
   end

   assign low_c     = to_lower(ch);
   assign d_c       = digit_of(ch, eff.radix_sel);
   assign d_held    = digit_of(eff.held_char, RX_DEC);
   assign d_hex     = digit_of(ch, RX_HEX);
   assign two_dec   = ({3'd0, d_held.val} << 3) + ({3'd0, d_held.val} << 1)
                      + {3'd0, d_c.val};
   assign limit_dec = eff.digit_limit - 5'd1;

   // Multiply by the base as shifts, with one add for decimal.
   always_comb begin
      case (eff.radix_sel)
         RX_HEX, RX_HEX_LONG: scaled = eff.accum << 4;
         RX_BIN:              scaled = eff.accum << 1;
         default:             scaled = (eff.accum << 3) + (eff.accum << 1);
      endcase
   end

   always_comb begin
      nxt  = eff;
      emit = 1'b0;
      res  = finish(eff.accum, eff.negative, ch, eff.char_count);
      case (eff.phase)
         PH_HEX: begin
            res.kind  = (eff.radix_sel == RX_HEX_LONG) ? KIND_ULONG : KIND_UINT;
            res.value = eff.accum;
            res.consumed  = eff.char_count;
            res.stop_char = ch;
            if (!d_hex.ok) begin
               emit = 1'b1;
            end else begin
               nxt.accum       = (eff.accum << 4) + {60'd0, d_hex.val};
               nxt.char_count  = count_up(eff.char_count, 2'd1);
               nxt.digit_limit = limit_dec;
               if (limit_dec == 5'd0) begin
                  emit          = 1'b1;
                  res.value     = nxt.accum;
                  res.consumed  = nxt.char_count;
                  res.stop_char = 8'd0;
               end
            end
         end
         PH_SIGN: begin
            if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_SPACE) begin
               if (ch == CH_MINUS) begin
                  nxt.negative = !eff.negative;
               end
               nxt.char_count = count_up(eff.char_count, 2'd1);
            end else begin
               nxt.held_char = ch;
               nxt.phase     = PH_LOOK;
            end
         end
         PH_LOOK: begin
            nxt.phase = PH_DIGITS;
            if (low_c == CH_LOWER_X || low_c == CH_LOWER_B) begin
               nxt.radix_sel  = (low_c == CH_LOWER_X) ? RX_HEX : RX_BIN;
               nxt.char_count = count_up(eff.char_count, 2'd2);
            end else if (!d_held.ok) begin
               // The held character stops the literal; the lookahead is dropped.
               emit = 1'b1;
               res  = finish(eff.accum, eff.negative, eff.held_char, eff.char_count);
            end else if (!d_c.ok) begin
               emit = 1'b1;
               res  = finish({60'd0, d_held.val}, eff.negative, ch,
                             count_up(eff.char_count, 2'd1));
            end else begin
               nxt.accum      = {57'd0, two_dec};
               nxt.char_count = count_up(eff.char_count, 2'd2);
            end
         end
         PH_DIGITS: begin
            if (!d_c.ok) begin
               emit = 1'b1;
            end else begin
               nxt.accum      = scaled + {60'd0, d_c.val};
               nxt.char_count = count_up(eff.char_count, 2'd1);
            end
         end
         default: begin
            nxt = eff;
         end
      endcase
      if (emit) begin
         nxt.phase = PH_IDLE;
      end
   end

endmodule

// ===== design/numeric_literal_parser.sv =====
// Top level of the numeric literal parser: stream ports, state and result registers.
//
// The parser takes one character per beat and can accept a beat in every cycle. Each
// character is decoded and folded into the accumulator by combinational logic between
// the parser state registers and a single result register, so a literal's result
// appears on the output in the cycle after the beat that ends it. The result register
// lets the input keep flowing while a result waits; the input stalls only when a
// result is held and the downstream side is not ready.
`include "assert_macros.svh"

module numeric_literal_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [nlp_pkg::REQ_DATA_W-1:0]      req_tdata,  // ch[7:0], hex_bytes[11:8]
   input  logic                                req_tuser,  // start_req
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [nlp_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // value, consumed, stop_char
   output logic [nlp_pkg::KIND_W-1:0]          rsp_tuser   // kind
);
   import nlp_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type step_res;
   logic       step_emit;
   logic       req_acc;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   nlp_step u_step (
      .cur       (state_ff),
      .ch        (req_tdata[7:0]),
      .start_req (req_tuser),
      .hex_bytes (req_tdata[11:8]),
      .nxt       (state_in),
      .emit      (step_emit),
      .res       (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_IDLE;
         state_ff.accum       <= 64'd0;
         state_ff.negative    <= 1'b0;
         state_ff.radix_sel   <= RX_DEC;
         state_ff.held_char   <= 8'd0;
         state_ff.char_count  <= 8'd0;
         state_ff.digit_limit <= 5'd0;
      end else if (req_acc) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc && step_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && step_emit) begin
         rsp_data_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.stop_char, rsp_data_ff.consumed, rsp_data_ff.value};
   assign rsp_tuser  = rsp_data_ff.kind;

   // A character outside any literal must never produce a result beat.
   `NLP_ASSERT(a_idle_silent, clock, reset, (req_acc && !req_tuser && state_ff.phase == PH_IDLE) |=> (!rsp_valid_ff || $past(rsp_valid_ff && !rsp_tready)), "result from an idle character")
   // A float literal always reports a zero value.
   `NLP_ASSERT(a_float_zero, clock, reset, (rsp_valid_ff && rsp_data_ff.kind == KIND_FLOAT) |-> (rsp_data_ff.value == 64'd0), "float literal with nonzero value")
   // Every emitted result closes the literal.
   `NLP_ASSERT(a_emit_idle, clock, reset, (req_acc && step_emit) |=> (state_ff.phase == PH_IDLE), "parser not idle after a result")

endmodule

// ===== sim/literal_result_checker.sv =====
// Checker for the numeric literal parser: predicts each literal's result and compares it.
`timescale 1ns / 1ps

module literal_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [nlp_pkg::REQ_DATA_W-1:0] req_tdata,   // ch[7:0], hex_bytes[11:8]
   input  logic                           req_tuser,   // start_req
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // value[63:0], consumed[71:64], stop_char[79:72]
   input  logic [nlp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [nlp_pkg::KIND_W-1:0]     rsp_tuser,   // kind
   output int                             mismatches,
   output int                             pending
);
   import nlp_pkg::*;

   localparam logic [4:0] NOT_A_DIGIT = 5'h1F;

   phase_type   lit_phase;
   logic [63:0] lit_accum;
   logic        lit_negative;
   radix_type   lit_radix;
   logic [7:0]  lit_held;
   logic [7:0]  lit_count;
   logic [4:0]  lit_budget;

   result_type expected_literals[$];
   int         fail_count = 0;

   function automatic logic [7:0] lower_char(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
   endfunction

   function automatic logic [4:0] digit_value(input logic [7:0] c, input radix_type rx);
      logic [7:0] l;
      l = lower_char(c);
      if (rx == RX_BIN) begin
         return (c == CH_ZERO || c == CH_ONE) ? 5'(c - CH_ZERO) : NOT_A_DIGIT;
      end
      if (c >= CH_ZERO && c <= CH_NINE) begin
         return 5'(c - CH_ZERO);
      end
      if (rx != RX_DEC && l >= CH_LOWER_A && l <= CH_LOWER_F) begin
         return 5'(l - CH_LOWER_A + 8'd10);
      end
      return NOT_A_DIGIT;
   endfunction

   task automatic clear_literal_state();
      lit_phase    = PH_IDLE;
      lit_accum    = '0;
      lit_negative = 1'b0;
      lit_radix    = RX_DEC;
      lit_held     = '0;
      lit_count    = '0;
      lit_budget   = '0;
   endtask

   task automatic count_chars(input int n);
      logic [8:0] sum;
      sum = {1'b0, lit_count} + 9'(n);
      lit_count = (sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : sum[7:0];
   endtask

   task automatic close_literal(input logic [63:0] value, input logic [KIND_W-1:0] kind,
                                input logic [7:0] stop, output result_type r);
      r.value     = value;
      r.kind      = kind;
      r.consumed  = lit_count;
      r.stop_char = stop;
      lit_phase   = PH_IDLE;
   endtask

   // The stop character picks the type: a long suffix, a float marker, or a plain int.
   task automatic end_general(input logic [7:0] c, output result_type r);
      logic [7:0] s;
      s = lower_char(c);
      if (s == CH_LOWER_L) begin
         count_chars(1);
         if (lit_negative) begin
            close_literal(-lit_accum, KIND_LONG, c, r);
         end else begin
            close_literal(lit_accum, KIND_ULONG, c, r);
         end
      end else if (s == CH_DOT || s == CH_LOWER_E || s == CH_LOWER_D || s == CH_LOWER_F) begin
         close_literal(64'd0, KIND_FLOAT, c, r);
      end else if (lit_negative) begin
         close_literal({lit_accum[63:32], -lit_accum[31:0]}, KIND_INT, c, r);
      end else begin
         close_literal(lit_accum, KIND_UINT, c, r);
      end
   endtask

   task automatic take_digit(input logic [7:0] c, output logic done, output result_type r);
      logic [4:0]  d;
      logic [63:0] base;
      d = digit_value(c, lit_radix);
      base = (lit_radix == RX_HEX) ? 64'd16 : (lit_radix == RX_BIN) ? 64'd2 : 64'd10;
      done = 1'b0;
      if (d == NOT_A_DIGIT) begin
         end_general(c, r);
         done = 1'b1;
      end else begin
         lit_accum = lit_accum * base + 64'(d);
         count_chars(1);
      end
   endtask

   task automatic parse_char(input logic [7:0] c, input logic first, input logic [3:0] hb,
                             output logic done, output result_type r);
      logic [4:0] d;
      logic [7:0] l;
      done = 1'b0;
      r = '0;
      if (first) begin
         lit_accum    = '0;
         lit_negative = 1'b0;
         lit_held     = '0;
         lit_count    = '0;
         if (hb != 4'd0) begin
            lit_budget = {hb, 1'b0};
            lit_radix  = ({4'd0, hb} == HEX_LONG_BYTES) ? RX_HEX_LONG : RX_HEX;
            lit_phase  = PH_HEX;
         end else begin
            lit_budget = '0;
            lit_radix  = RX_DEC;
            lit_phase  = PH_SIGN;
         end
      end
      case (lit_phase)
         PH_HEX: begin
            d = digit_value(c, RX_HEX);
            if (d == NOT_A_DIGIT) begin
               close_literal(lit_accum, (lit_radix == RX_HEX_LONG) ? KIND_ULONG : KIND_UINT,
                             c, r);
               done = 1'b1;
            end else begin
               lit_accum = {lit_accum[59:0], d[3:0]};
               count_chars(1);
               lit_budget = lit_budget - 5'd1;
               // A full digit budget closes the literal on its last digit, with no stop.
               if (lit_budget == 5'd0) begin
                  close_literal(lit_accum,
                                (lit_radix == RX_HEX_LONG) ? KIND_ULONG : KIND_UINT, 8'd0, r);
                  done = 1'b1;
               end
            end
         end
         PH_SIGN: begin
            if (c == CH_PLUS || c == CH_MINUS || c == CH_SPACE) begin
               if (c == CH_MINUS) begin
                  lit_negative = !lit_negative;
               end
               count_chars(1);
            end else begin
               lit_held  = c;
               lit_phase = PH_LOOK;
            end
         end
         PH_LOOK: begin
            l = lower_char(c);
            lit_phase = PH_DIGITS;
            if (l == CH_LOWER_X || l == CH_LOWER_B) begin
               lit_radix = (l == CH_LOWER_X) ? RX_HEX : RX_BIN;
               count_chars(2);
            end else begin
               // The held character goes first; if it stops the literal, this one is dropped.
               take_digit(lit_held, done, r);
               if (!done) begin
                  take_digit(c, done, r);
               end
            end
         end
         PH_DIGITS: begin
            take_digit(c, done, r);
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      result_type fresh;
      logic       done;
      if (reset) begin
         clear_literal_state();
         expected_literals.delete();
      end else begin
         // A result beat always belongs to a character accepted on an earlier edge.
         if (rsp_tvalid && rsp_tready) begin
            got.value     = rsp_tdata[63:0];
            got.consumed  = rsp_tdata[71:64];
            got.stop_char = rsp_tdata[79:72];
            got.kind      = rsp_tuser;
            if (expected_literals.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got value %h kind %0d",
                        $time, got.value, got.kind);
               fail_count++;
            end else begin
               want = expected_literals.pop_front();
               check_field("value", want.value, got.value);
               check_field("kind", 64'(want.kind), 64'(got.kind));
               check_field("consumed", 64'(want.consumed), 64'(got.consumed));
               check_field("stop_char", 64'(want.stop_char), 64'(got.stop_char));
            end
         end
         if (req_tvalid && req_tready) begin
            parse_char(req_tdata[7:0], req_tuser, req_tdata[11:8], done, fresh);
            if (done) begin
               expected_literals.push_back(fresh);
            end
         end
      end
      pending    <= expected_literals.size();
      mismatches <= fail_count;
   end

endmodule

// ===== sim/numeric_literal_parser_tb.sv =====
// Testbench top for the numeric literal parser: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

module numeric_literal_parser_tb;
   import nlp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // ch[7:0], hex_bytes[11:8]
   logic                  req_tuser  = 1'b0; // start_req
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // value[63:0], consumed[71:64], stop_char[79:72]
   logic [KIND_W-1:0]     rsp_tuser;         // kind

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches;
   int pending;
   int stuck;

   numeric_literal_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   literal_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [7:0] flip_case(input logic [7:0] c);
      return $urandom_range(1) ? c - CASE_GAP : c;
   endfunction

   function automatic logic [7:0] random_digit(input radix_type rx);
      int v;
      case (rx)
         RX_BIN: return CH_ZERO + 8'($urandom_range(1));
         RX_DEC: return CH_ZERO + 8'($urandom_range(9));
         default: begin
            v = $urandom_range(15);
            return (v < 10) ? CH_ZERO + 8'(v) : flip_case(CH_LOWER_A + 8'(v - 10));
         end
      endcase
   endfunction

   function automatic logic [7:0] random_sign();
      case ($urandom_range(2))
         0: return CH_PLUS;
         1: return CH_MINUS;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] random_stop();
      case ($urandom_range(9))
         0: return flip_case(CH_LOWER_L);
         1: return CH_DOT;
         2: return flip_case(CH_LOWER_E);
         3: return flip_case(CH_LOWER_D);
         4: return flip_case(CH_LOWER_F);
         5: return CH_SPACE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_char(input logic [7:0] c, input logic first, input logic [3:0] hb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, hb, c};
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_text(input string s, input logic [3:0] hb);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == 0, hb);
      end
   endtask

   // Holds the stream off until every literal already closed has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_random_literal(input bit long_lead, output int sent);
      logic [7:0] text[$];
      logic [3:0] hb;
      radix_type  rx;
      int         ndig;
      int         pick;
      // Now and then stray characters arrive between literals.
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            send_char(8'($urandom_range(255)), 1'b0, 4'($urandom_range(15)));
         end
      end
      if (!long_lead && $urandom_range(3) == 0) begin
         hb = ($urandom_range(7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
         ndig = $urandom_range(0, 2 * hb);
         repeat (ndig) text.push_back(random_digit(RX_HEX));
         if (ndig < 2 * hb) begin
            text.push_back(8'($urandom_range(255)));
         end
      end else begin
         hb = 4'd0;
         repeat (long_lead ? $urandom_range(260, 300) : $urandom_range(0, 3)) begin
            text.push_back(random_sign());
         end
         pick = $urandom_range(9);
         if (pick < 5) begin
            rx = (pick < 3) ? RX_HEX : RX_BIN;
            text.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CH_ZERO);
            text.push_back(flip_case((rx == RX_HEX) ? CH_LOWER_X : CH_LOWER_B));
            if (rx == RX_HEX) begin
               ndig = $urandom_range(0, 17);
            end else begin
               ndig = ($urandom_range(4) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 8);
            end
         end else if (pick < 9) begin
            rx = RX_DEC;
            ndig = $urandom_range(1, 21);
         end else begin
            rx = RX_DEC;
            text.push_back(8'($urandom_range(255)));
            ndig = $urandom_range(0, 3);
         end
         repeat (ndig) text.push_back(random_digit(rx));
         // Without a stop the next literal's start abandons this one.
         if ($urandom_range(7) != 0) begin
            text.push_back(random_stop());
         end
      end
      foreach (text[i]) begin
         send_char(text[i], i == 0, (i == 0) ? hb : 4'($urandom_range(15)));
      end
      sent = text.size();
   endtask

   initial begin
      stuck = 0;
      while (stuck < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stuck = 0;
         end else begin
            stuck++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int total;
      int sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("-7,", 4'd0);
      send_text("0XfF.", 4'd0);
      send_text("-0b101L", 4'd0);
      send_text("a5", 4'd0);
      send_text("1e", 4'd0);
      send_text("F0", 4'd1);
      send_text("Z", 4'd8);
      send_char(8'h00, 1'b0, 4'd0);
      send_char(8'hFF, 1'b0, 4'hF);
      send_text("9", 4'd0);
      send_text("1234", 4'd2);
      send_text("+ 42", 4'd0);
      send_char(8'hFF, 1'b0, 4'd0);
      wait_for_results();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         total = 0;
         while (total < 100) begin
            // One literal with a very long sign run drives the consumed count into saturation.
            send_random_literal(p == 2 && total == 0, sent);
            total += sent;
         end
         wait_for_results();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
